>>> design/lmsc_pkg.sv
// Shared types, constants and the letter binning function for the letter subset checker.
package lmsc_pkg;

	localparam int BIN_COUNT  = 26;
	localparam int BIN_W      = 5;
	localparam int COUNT_W    = 6;
	localparam int BIN_OFFSET = 13;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	typedef logic [BIN_W-1:0]   bin_t;
	typedef logic [COUNT_W-1:0] count_t;

	// One classified letter on its way from the front to the back.
	typedef struct packed {
		logic cand;
		bin_t bin;
		logic last;
	} op_t;

	// Bin is (code + 13) mod 26. The quotient comes from a multiply by 79/2048,
	// which is exact for every sum below 269.
	function automatic bin_t letter_bin(input logic [7:0] code);
		logic [8:0]  sum;
		logic [15:0] prod;
		logic [4:0]  quot;
		logic [8:0]  rem;
		sum  = {1'b0, code} + 9'(BIN_OFFSET);
		prod = 16'(sum) * 16'd79;
		quot = prod[15:11];
		rem  = sum - 9'(quot) * 9'(BIN_COUNT);
		return rem[BIN_W-1:0];
	endfunction

endpackage

>>> design/lmsc_front.sv
// Front end: takes letters, works out their bin and holds them in a short queue.
module lmsc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             in_cand,
	input  logic [7:0]       in_letter,
	input  logic             in_last,
	output logic             op_valid,
	input  logic             op_ready,
	output lmsc_pkg::op_t    op
);
	import lmsc_pkg::*;

	op_t        entry_q [QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	logic       pop;

	assign in_ready = (fill_q != 2'(QUEUE_DEPTH));
	assign op_valid = (fill_q != 2'd0);
	assign op       = entry_q[rd_ptr_q];
	assign push     = in_valid & in_ready;
	assign pop      = op_valid & op_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= '{cand: in_cand, bin: letter_bin(in_letter), last: in_last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end

endmodule

>>> design/lmsc_back.sv
// Back end: keeps both words' letter counts and checks the candidate against the reference.
module lmsc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             op_valid,
	output logic             op_ready,
	input  lmsc_pkg::op_t    op,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             out_contained
);
	import lmsc_pkg::*;

	count_t ref_cnt_q  [BIN_COUNT];
	count_t cand_cnt_q [BIN_COUNT];
	count_t side_nxt   [BIN_COUNT];
	logic   ref_fresh_q;
	logic   cand_fresh_q;
	logic   out_valid_q;
	logic   contained_q;
	logic   side_fresh;
	logic   is_result;
	logic   fits;
	logic   take;

	assign side_fresh = op.cand ? cand_fresh_q : ref_fresh_q;
	assign is_result  = op.cand & op.last;
	// An item that yields no result never waits for the output register.
	assign op_ready   = ~is_result | ~out_valid_q | out_ready;
	assign take       = op_valid & op_ready;

	// Counts of the chosen side after this letter, all bins at once.
	always_comb begin
		count_t cur;
		for (int i = 0; i < BIN_COUNT; i++) begin
			cur = op.cand ? cand_cnt_q[i] : ref_cnt_q[i];
			if (side_fresh) begin
				cur = '0;
			end
			if ((op.bin == BIN_W'(i)) && (cur != COUNT_MAX)) begin
				side_nxt[i] = cur + count_t'(1);
			end else begin
				side_nxt[i] = cur;
			end
		end
	end

	always_comb begin
		fits = 1'b1;
		for (int i = 0; i < BIN_COUNT; i++) begin
			if (side_nxt[i] > ref_cnt_q[i]) begin
				fits = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BIN_COUNT; i++) begin
				ref_cnt_q[i]  <= '0;
				cand_cnt_q[i] <= '0;
			end
			ref_fresh_q  <= 1'b1;
			cand_fresh_q <= 1'b1;
		end else if (take) begin
			if (op.cand) begin
				cand_cnt_q   <= side_nxt;
				cand_fresh_q <= op.last;
			end else begin
				ref_cnt_q   <= side_nxt;
				ref_fresh_q <= op.last;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (take && is_result) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && is_result) begin
			contained_q <= fits;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_contained = contained_q;

endmodule

>>> design/letter_multiset_subset_check.sv
// Top level of the letter subset checker: stream ports around the front and back ends.
//
// Letters arrive on the s_axis channel, one item each. tuser selects the word:
// 0 for the reference word, 1 for the candidate word; tlast marks a word's final
// letter. Each letter is counted in bin (code + 13) mod 26, with counts
// saturating at 63. The first letter after a word's end clears that word's counts.
// On a candidate's final letter one item leaves on m_axis: tdata bit 0 is 1 when
// no candidate count exceeds the matching reference count.
// Throughput is one letter per cycle unless a second result stalls the queue; the 26
// bin comparisons run in parallel in the back end. A result passes the queue and then
// the output register before it becomes valid. A two-entry queue sits between the
// front and back ends, and the result is held in an output register, so the input
// keeps flowing while a result waits. If the receiver stalls with a result pending,
// letters that produce no result still go through; a second result holds the queue
// until the first is taken. After reset both words' counts are zero and both sides
// start a new word.
module letter_multiset_subset_check (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] letter
	input  logic       s_axis_tuser,   // [0] cmd
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata    // [0] contained, [7:1] zero
);
	import lmsc_pkg::*;

	op_t  op;
	logic op_valid;
	logic op_ready;
	logic contained;

	lmsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cand   (s_axis_tuser),
		.in_letter (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.op_valid  (op_valid),
		.op_ready  (op_ready),
		.op        (op)
	);

	lmsc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.op_valid      (op_valid),
		.op_ready      (op_ready),
		.op            (op),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_contained (contained)
	);

	assign m_axis_tdata = {7'd0, contained};

endmodule
